>>> rtl/core/petq_pkg.sv
// Shared types and constants for the phased event time queue.
package petq_pkg;

    localparam int DEF_SLOTS = 16;
    localparam int ID_W      = 4;
    localparam int TIME_W    = 50;
    localparam int NOW_W     = 48;
    localparam int DELAY_W   = 32;
    localparam int CNT_OUT_W = 5;

    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_CANCEL   = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [ID_W-1:0]    event_id;
        logic [DELAY_W-1:0] delay_cycles;
        logic               phase;
        logic [NOW_W-1:0]   now;
    } t_in_item;

    typedef struct packed {
        logic                 was_pending;
        logic                 head_valid;
        logic [ID_W-1:0]      head_id;
        logic [TIME_W-1:0]    head_time;
        logic [CNT_OUT_W-1:0] pending_count;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic accept;
        logic insert;
        logic load;
    } t_dp_cmd;

endpackage

>>> rtl/core/petq_in_if.sv
// Request channel carrying queue operations into the block.
interface petq_in_if;
    logic                valid;
    logic                ready;
    petq_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/petq_out_if.sv
// Result channel carrying queue head and count out of the block.
interface petq_out_if;
    logic                valid;
    logic                ready;
    petq_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/petq_ctrl.sv
// Controller state machine sequencing remove, insert and result load.
module petq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output petq_pkg::t_dp_cmd o_cmd
);

    petq_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            petq_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = petq_pkg::ST_INSERT;
            end
            petq_pkg::ST_INSERT: begin
                n_state = out_free ? petq_pkg::ST_IDLE : petq_pkg::ST_HOLD;
            end
            petq_pkg::ST_HOLD: begin
                if (out_free) n_state = petq_pkg::ST_IDLE;
            end
            default: n_state = petq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.insert = 1'b0;
        o_cmd.load   = 1'b0;
        case (r_state)
            petq_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            petq_pkg::ST_INSERT: begin
                o_cmd.insert = 1'b1;
                o_cmd.load   = out_free;
            end
            petq_pkg::ST_HOLD: begin
                o_cmd.load = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= petq_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/petq_dp.sv
// Datapath: sorted slot row with parallel remove and compare-and-shift insert.
module petq_dp #(
    parameter int SLOTS = petq_pkg::DEF_SLOTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  petq_pkg::t_dp_cmd   i_cmd,
    input  petq_pkg::t_in_item  i_item,
    output petq_pkg::t_out_item o_item
);

    localparam int CW  = $clog2(SLOTS + 1);
    localparam int CXW = CW + petq_pkg::CNT_OUT_W;

    logic [petq_pkg::ID_W-1:0]   r_ids   [SLOTS];
    logic [petq_pkg::TIME_W-1:0] r_times [SLOTS];
    logic [petq_pkg::ID_W-1:0]   n_ids   [SLOTS];
    logic [petq_pkg::TIME_W-1:0] n_times [SLOTS];
    logic [SLOTS-1:0]            r_valid, n_valid;
    logic [CW-1:0]               r_count, n_count;

    logic [petq_pkg::TIME_W-1:0] r_trig;
    logic [petq_pkg::ID_W-1:0]   r_eid;
    logic                        r_was;
    logic                        r_do_ins;
    petq_pkg::t_out_item         r_out;

    logic [SLOTS-1:0]            match;
    logic [SLOTS-1:0]            after_hit;
    logic [SLOTS-1:0]            ins_m;
    logic                        rm_op;
    logic                        hit;
    logic                        was;
    logic [petq_pkg::TIME_W-1:0] trig;
    logic [CXW-1:0]              cnt_ext;

    assign rm_op = (i_item.opcode == petq_pkg::OP_SCHEDULE) ||
                   (i_item.opcode == petq_pkg::OP_CANCEL);

    // trigger = 2*delay + now + (now[0] ^ phase), never above 50 bits
    assign trig = {{(petq_pkg::TIME_W - petq_pkg::DELAY_W - 1){1'b0}},
                   i_item.delay_cycles, 1'b0}
                + {{(petq_pkg::TIME_W - petq_pkg::NOW_W){1'b0}}, i_item.now}
                + {{(petq_pkg::TIME_W - 1){1'b0}}, i_item.now[0] ^ i_item.phase};

    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            match[k] = r_valid[k] && (r_ids[k] == i_item.event_id);
        end
        // slot k shifts down once the removed entry sits at or before it
        for (int k = 0; k < SLOTS; k++) begin
            after_hit[k] = |(match << (SLOTS - 1 - k));
        end
        // slot k moves up (or takes the new entry) when it is free or later
        for (int k = 0; k < SLOTS; k++) begin
            ins_m[k] = !r_valid[k] || (r_times[k] > r_trig);
        end
    end

    assign hit = |match;
    assign was = rm_op && hit;

    always_comb begin
        n_ids   = r_ids;
        n_times = r_times;
        n_valid = r_valid;
        n_count = r_count;
        if (i_cmd.accept) begin
            if (i_item.opcode == petq_pkg::OP_CLEAR) begin
                n_valid = '0;
                n_count = '0;
            end else if (was) begin
                for (int k = 0; k < SLOTS - 1; k++) begin
                    if (after_hit[k]) begin
                        n_ids[k]   = r_ids[k+1];
                        n_times[k] = r_times[k+1];
                        n_valid[k] = r_valid[k+1];
                    end
                end
                if (after_hit[SLOTS-1]) n_valid[SLOTS-1] = 1'b0;
                n_count = r_count - 1'b1;
            end
        end
        if (i_cmd.insert && r_do_ins) begin
            if (ins_m[0]) begin
                n_ids[0]   = r_eid;
                n_times[0] = r_trig;
            end
            for (int k = 1; k < SLOTS; k++) begin
                if (ins_m[k]) begin
                    if (!ins_m[k-1]) begin
                        n_ids[k]   = r_eid;
                        n_times[k] = r_trig;
                    end else begin
                        n_ids[k]   = r_ids[k-1];
                        n_times[k] = r_times[k-1];
                    end
                end
            end
            n_valid = {r_valid[SLOTS-2:0], 1'b1};
            n_count = r_count + 1'b1;
        end
    end

    assign cnt_ext = CXW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ids   <= n_ids;
        r_times <= n_times;
        if (i_cmd.accept) begin
            r_trig   <= trig;
            r_eid    <= i_item.event_id;
            r_was    <= was;
            r_do_ins <= (i_item.opcode == petq_pkg::OP_SCHEDULE) &&
                        (hit || (r_count != CW'(SLOTS)));
        end
        if (i_cmd.load) begin
            r_out.was_pending   <= r_was;
            r_out.head_valid    <= n_valid[0];
            r_out.head_id       <= n_valid[0] ? n_ids[0] : '0;
            r_out.head_time     <= n_valid[0] ? n_times[0] : '0;
            r_out.pending_count <= cnt_ext[petq_pkg::CNT_OUT_W-1:0];
        end
    end

    assign o_item = r_out;

endmodule

>>> rtl/core/phased_event_time_queue.sv
// Top level of the phased event time queue: controller plus slot datapath.
//
// Usage: i_cmd carries schedule, cancel and clear requests, each with the
// current half-cycle time; o_res returns one result per request with the
// was-pending flag, the earliest pending event (id and trigger time) and
// the number of queued events. Both channels transfer on valid && ready.
// Sequence: a request accepted while the controller is idle removes the
// addressed id from the sorted slot row; the insert state then compares
// the trigger time against every slot in parallel, shifts in the new
// entry and loads the result when o_res is free. i_cmd.ready is high only
// while the controller is idle, so one request is handled at a time.
// Reset (synchronous, i_rst_n low) empties the queue and drops any result
// not yet taken; slot contents are not cleared.
// When the receiver stalls, the result stays in the output register and
// the next request is taken and processed; its result then waits in the
// datapath until o_res drains, and no further request is taken.
module phased_event_time_queue #(
    parameter int SLOTS = petq_pkg::DEF_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    petq_in_if.sink     i_cmd,
    petq_out_if.source  o_res
);

    petq_pkg::t_dp_cmd cmd;

    petq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd)
    );

    petq_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_cmd.data),
        .o_item  (o_res.data)
    );

endmodule
